// ===== design/itoa_pkg.sv =====
// Shared types, constants and a helper function for the integer to ASCII converter.
package itoa_pkg;

	localparam int VAL_W    = 32;
	localparam int NARROW_W = 16;
	localparam int DIGITS   = 10;
	localparam int DIG_W    = 4 * DIGITS;
	localparam int CHAR_W   = 7;
	localparam int CNT_W    = $clog2(VAL_W + 1);
	localparam int REM_W    = $clog2(DIGITS + 1);

	// Conversion kinds
	localparam logic [1:0] KIND_SDEC = 2'd0;
	localparam logic [1:0] KIND_UDEC = 2'd1;
	localparam logic [1:0] KIND_LHEX = 2'd2;
	localparam logic [1:0] KIND_UHEX = 2'd3;

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_UA    = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_LA    = 7'h61;

	// Converter status toward the top level
	typedef struct packed {
		logic busy;
		logic done;
	} cv_stat_t;

	// Finished digit string handed to the emitter
	typedef struct packed {
		logic [DIG_W-1:0] digits;
		logic             neg;
		logic             upper;
	} cv_result_t;

	typedef enum logic [1:0] {
		E_IDLE,
		E_SIGN,
		E_SKIP,
		E_DIGIT
	} emit_state_t;

	// Map one digit value to its ASCII code
	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
		logic [CHAR_W-1:0] r;
		if (d < 4'd10) begin
			r = CHAR_ZERO + {3'b000, d};
		end else if (upper) begin
			r = CHAR_UA + {3'b000, d - 4'd10};
		end else begin
			r = CHAR_LA + {3'b000, d - 4'd10};
		end
		return r;
	endfunction

endpackage

// ===== design/integer_to_ascii_converter.sv =====
// Top level of the integer to ASCII converter.
// The shifter converts decimal values bit by bit or loads hex directly, then hands the digits
// to the emitter, which writes a minus sign if needed and then the digits, skipping leading zeros.
// The shifter takes the next item once the emitter holds the digits, so one item converts while
// the last is still being emitted; the output stalls while m_tready is low.
// Reset: arst_n clears all control state asynchronously; the block is ready right after.
module integer_to_ascii_converter import itoa_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,   // [31:0] value
	input  logic [2:0]   s_tuser,   // [1:0] req_type, [2] is_wide
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata,   // [6:0] char_out, [7] zero fill
	output logic         m_tlast    // last
);

	cv_stat_t            cv_stat;
	cv_result_t          cv_result;
	logic                accept;
	logic                emit_idle;
	logic                handoff;
	logic [1:0]          req_type;
	logic                is_wide;
	logic [VAL_W-1:0]    mag_in;
	logic [VAL_W-1:0]    mag;
	logic                sign_bit;
	logic                neg;

	assign req_type = s_tuser[1:0];
	assign is_wide  = s_tuser[2];
	assign s_tready = !cv_stat.busy && !cv_stat.done;
	assign accept   = s_tvalid && s_tready;
	assign handoff  = cv_stat.done && emit_idle;

	// Select size, take the magnitude of negative signed values
	always_comb begin
		mag_in   = is_wide ? s_tdata : {{(VAL_W - NARROW_W){1'b0}}, s_tdata[NARROW_W-1:0]};
		sign_bit = is_wide ? s_tdata[VAL_W-1] : s_tdata[NARROW_W-1];
		neg      = (req_type == KIND_SDEC) && sign_bit;
		mag      = mag_in;
		if (neg) begin
			mag = ~mag_in + VAL_W'(1);
			if (!is_wide) begin
				mag[VAL_W-1:NARROW_W] = '0;
			end
		end
	end

	itoa_conv u_conv (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (accept),
		.mag     (mag),
		.is_wide (is_wide),
		.is_hex  (req_type == KIND_LHEX || req_type == KIND_UHEX),
		.neg     (neg),
		.upper   (is_wide && req_type == KIND_UHEX),
		.ack     (handoff),
		.stat    (cv_stat),
		.result  (cv_result)
	);

	itoa_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (handoff),
		.result   (cv_result),
		.idle     (emit_idle),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== design/itoa_conv.sv =====
// Bit-serial binary to BCD converter (shift and add-3), with direct nibble load for hex.
module itoa_conv import itoa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [VAL_W-1:0]   mag,
	input  logic               is_wide,
	input  logic               is_hex,
	input  logic               neg,
	input  logic               upper,
	input  logic               ack,
	output cv_stat_t           stat,
	output cv_result_t         result
);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [VAL_W-1:0]   bin_q;
	logic [DIG_W-1:0]   bcd_q;
	logic               neg_q;
	logic               upper_q;
	logic [DIG_W-1:0]   bcd_adj;

	// Add three to every BCD digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// Control flags: busy while shifting, done until the emitter takes the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (start && !is_hex) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
			if ((start && is_hex) || (busy_q && cnt_q == CNT_W'(1))) begin
				done_q <= 1'b1;
			end else if (ack) begin
				done_q <= 1'b0;
			end
		end
	end

	// Datapath: load, then for decimal shift one binary bit into the BCD register per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q   <= neg;
			upper_q <= upper;
			if (is_hex) begin
				bcd_q <= {{(DIG_W - VAL_W){1'b0}}, mag};
			end else begin
				bcd_q <= '0;
				if (is_wide) begin
					bin_q <= mag;
					cnt_q <= CNT_W'(VAL_W);
				end else begin
					bin_q <= {mag[NARROW_W-1:0], {(VAL_W - NARROW_W){1'b0}}};
					cnt_q <= CNT_W'(NARROW_W);
				end
			end
		end else if (busy_q) begin
			bcd_q <= {bcd_adj[DIG_W-2:0], bin_q[VAL_W-1]};
			bin_q <= {bin_q[VAL_W-2:0], 1'b0};
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign stat.busy     = busy_q;
	assign stat.done     = done_q;
	assign result.digits = bcd_q;
	assign result.neg    = neg_q;
	assign result.upper  = upper_q;

endmodule

// ===== design/itoa_emit.sv =====
// Emitter: sign, leading-zero skip, a digit per cycle unless stalled, to an output register.
module itoa_emit import itoa_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  cv_result_t   result,
	output logic         idle,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata,   // [6:0] char_out, [7] zero fill
	output logic         m_tlast    // last
);

	emit_state_t         state_q;
	emit_state_t         state_d;
	logic [DIG_W-1:0]    dig_q;
	logic [REM_W-1:0]    rem_q;
	logic                upper_q;
	logic                valid_q;
	logic [CHAR_W-1:0]   char_q;
	logic                last_q;
	logic                out_free;
	logic                push;
	logic                shift;
	logic [CHAR_W-1:0]   push_char;
	logic                push_last;
	logic [3:0]          top_dig;

	assign out_free = !valid_q || m_tready;
	assign top_dig  = dig_q[DIG_W-1 -: 4];

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			E_IDLE: begin
				if (load) begin
					state_d = result.neg ? E_SIGN : E_SKIP;
				end
			end
			E_SIGN: begin
				if (out_free) begin
					state_d = E_SKIP;
				end
			end
			E_SKIP: begin
				if (!(top_dig == 4'd0 && rem_q > REM_W'(1))) begin
					state_d = E_DIGIT;
				end
			end
			E_DIGIT: begin
				if (out_free && rem_q == REM_W'(1)) begin
					state_d = E_IDLE;
				end
			end
			default: state_d = E_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		push      = 1'b0;
		shift     = 1'b0;
		push_char = CHAR_MINUS;
		push_last = 1'b0;
		case (state_q)
			E_IDLE: begin
			end
			E_SIGN: begin
				push = out_free;
			end
			E_SKIP: begin
				shift = (top_dig == 4'd0 && rem_q > REM_W'(1));
			end
			E_DIGIT: begin
				push      = out_free;
				shift     = out_free;
				push_char = digit_char(top_dig, upper_q);
				push_last = (rem_q == REM_W'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (push) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Digit shift register and output payload
	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && load) begin
			dig_q   <= result.digits;
			rem_q   <= REM_W'(DIGITS);
			upper_q <= result.upper;
		end else if (shift) begin
			dig_q <= {dig_q[DIG_W-5:0], 4'd0};
			rem_q <= rem_q - REM_W'(1);
		end
		if (push) begin
			char_q <= push_char;
			last_q <= push_last;
		end
	end

	assign idle     = (state_q == E_IDLE);
	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, char_q};
	assign m_tlast  = last_q;

endmodule

// ===== design/itoa_checker.sv =====
// Port-level checker for the integer to ASCII converter, bound to the top level.
module itoa_checker import itoa_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);

	// Hold a stalled transaction
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output transaction changed while stalled");

	// Take at most one item into the shifter at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while converter still owns an item");

	// Never end a number on the minus sign
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[6:0] == CHAR_MINUS |-> !m_tlast)
		else $error("minus sign marked as last character");

	// Keep the fill bit of the character clear
	a_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[7])
		else $error("character outside 7-bit range");

endmodule

bind integer_to_ascii_converter itoa_checker u_itoa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== test/integer_to_ascii_converter_tb.sv =====
// Self-checking testbench for the integer to ASCII converter.
`timescale 1ns / 100ps

module integer_to_ascii_converter_tb;
	import itoa_pkg::*;

	localparam int RANDOM_NUMBERS = 250;
	localparam int TAIL_ITEMS     = 30;
	localparam int DRAIN_CYCLES   = 48;

	// One number to convert
	typedef struct packed {
		logic [1:0]  kind;
		logic        wide;
		logic [31:0] value;
	} number_req_t;

	// One expected output character
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              fin;
	} glyph_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;   // [31:0] value
	logic [2:0]  s_tuser  = '0;   // [1:0] req_type, [2] is_wide
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;         // [6:0] char_out, [7] zero fill
	logic        m_tlast;

	number_req_t pending_numbers[$];
	glyph_t      expected_glyphs[$];
	int          total_numbers   = 0;
	int          accepted_count  = 0;
	int          fail_count      = 0;
	int          tx_gap          = 0;
	int          tx_run          = 0;
	int          rx_gap          = 0;
	int          rx_run          = 0;

	integer_to_ascii_converter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Work out the text of one number and queue its characters
	function automatic void predict_text(logic [1:0] kind, logic wide, logic [31:0] value);
		logic [31:0]       width_mask;
		logic [31:0]       mag;
		logic              neg;
		logic              hex_mode;
		logic              upper_case;
		logic [3:0]        digit;
		logic [CHAR_W-1:0] rev[10];
		int                nd;
		glyph_t            g;
		width_mask = wide ? 32'hFFFF_FFFF : 32'h0000_FFFF;
		mag        = value & width_mask;
		neg        = (kind == KIND_SDEC) && (wide ? mag[31] : mag[15]);
		hex_mode   = (kind == KIND_LHEX) || (kind == KIND_UHEX);
		// narrow hex always comes out lower case
		upper_case = wide && (kind == KIND_UHEX);
		if (neg) begin
			mag   = (~mag + 32'd1) & width_mask;
			g.ch  = CHAR_MINUS;
			g.fin = 1'b0;
			expected_glyphs.push_back(g);
		end
		// collect digits least significant first
		nd = 0;
		do begin
			digit = hex_mode ? mag[3:0] : 4'(mag % 32'd10);
			if (digit < 4'd10)
				rev[nd] = CHAR_ZERO + CHAR_W'(digit);
			else
				rev[nd] = (upper_case ? CHAR_UA : CHAR_LA) + CHAR_W'(digit - 4'd10);
			nd++;
			mag = hex_mode ? (mag >> 4) : (mag / 32'd10);
		end while (mag != 32'd0 && nd < 10);
		for (int i = nd - 1; i >= 0; i--) begin
			g.ch  = rev[i];
			g.fin = (i == 0);
			expected_glyphs.push_back(g);
		end
	endfunction

	task automatic add_number(logic [1:0] kind, logic wide, logic [31:0] value);
		number_req_t r;
		r.kind  = kind;
		r.wide  = wide;
		r.value = value;
		pending_numbers.push_back(r);
		total_numbers++;
	endtask

	task automatic report_mismatch(string what);
		$display("%0t ns: mismatch: %s", $time, what);
		fail_count++;
	endtask

	// Driver: present numbers, with random gaps between transactions
	always @(posedge clk or negedge arst_n) begin
		number_req_t nxt;
		logic        send;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_text(s_tuser[1:0], s_tuser[2], s_tdata);
				accepted_count++;
			end
			if (!s_tvalid || s_tready) begin
				send = 1'b0;
				if (pending_numbers.size() > 0) begin
					if (tx_gap > 0) begin
						tx_gap--;
					end else begin
						send = 1'b1;
						if (pending_numbers.size() > TAIL_ITEMS) begin
							if (tx_run > 0)
								tx_run--;
							else if ($urandom_range(0, 1))
								tx_gap = $urandom_range(1, 17);
							else
								tx_run = $urandom_range(1, 30);
						end
					end
				end
				if (send) begin
					nxt = pending_numbers.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.value;
					s_tuser  <= {nxt.wide, nxt.kind};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each character, stall the output at random
	always @(posedge clk or negedge arst_n) begin
		glyph_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_glyphs.size() == 0) begin
					report_mismatch($sformatf("unexpected char %0h last %0b",
						m_tdata[6:0], m_tlast));
				end else begin
					want = expected_glyphs.pop_front();
					if (m_tdata[6:0] !== want.ch)
						report_mismatch($sformatf("char %0h, want %0h",
							m_tdata[6:0], want.ch));
					if (m_tlast !== want.fin)
						report_mismatch($sformatf("last %0b, want %0b on char %0h",
							m_tlast, want.fin, want.ch));
					if (m_tdata[7] !== 1'b0)
						report_mismatch("fill bit of tdata not zero");
				end
			end
			if (rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (pending_numbers.size() > TAIL_ITEMS) begin
					if (rx_run > 0)
						rx_run--;
					else if ($urandom_range(0, 1))
						rx_gap = $urandom_range(1, 17);
					else
						rx_run = $urandom_range(1, 30);
				end
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin
		logic [1:0]  kind;
		logic        wide;
		logic [31:0] value;
		logic [31:0] pow;

		// zero in every kind and in both sizes, junk in the unused upper half of the first
		add_number(KIND_SDEC, 1'b0, 32'hFFFF_0000);
		add_number(KIND_SDEC, 1'b1, 32'h0000_0000);
		add_number(KIND_UDEC, 1'b0, 32'h0000_0000);
		add_number(KIND_LHEX, 1'b1, 32'h0000_0000);
		add_number(KIND_UHEX, 1'b0, 32'h0000_0000);
		// narrow sign handling, most negative narrow value
		add_number(KIND_SDEC, 1'b0, 32'h1234_8000);
		add_number(KIND_SDEC, 1'b0, 32'h0000_7FFF);
		add_number(KIND_SDEC, 1'b0, 32'hABCD_FFFF);
		// wide sign handling, most negative wide value
		add_number(KIND_SDEC, 1'b1, 32'h8000_0000);
		add_number(KIND_SDEC, 1'b1, 32'h7FFF_FFFF);
		add_number(KIND_SDEC, 1'b1, 32'hFFFF_FFFF);
		// unsigned never gets a minus
		add_number(KIND_UDEC, 1'b1, 32'hFFFF_FFFF);
		add_number(KIND_UDEC, 1'b0, 32'hFFFF_FFFF);
		add_number(KIND_UDEC, 1'b1, 32'h8000_0000);
		add_number(KIND_UDEC, 1'b1, 32'd9);
		add_number(KIND_UDEC, 1'b1, 32'd10);
		// hex cases, narrow upper hex stays lower case
		add_number(KIND_LHEX, 1'b1, 32'hDEAD_BEEF);
		add_number(KIND_UHEX, 1'b1, 32'hDEAD_BEEF);
		add_number(KIND_UHEX, 1'b1, 32'hFFFF_FFFF);
		add_number(KIND_LHEX, 1'b0, 32'h5555_ABCD);
		add_number(KIND_UHEX, 1'b0, 32'hAAAA_ABCD);
		add_number(KIND_UHEX, 1'b1, 32'h0000_000F);
		add_number(KIND_LHEX, 1'b1, 32'h1000_0000);
		add_number(KIND_LHEX, 1'b1, 32'h8000_0000);

		// random numbers, biased toward digit-count and sign boundaries
		repeat (RANDOM_NUMBERS) begin
			kind = 2'($urandom_range(0, 3));
			wide = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 5))
				0: value = $urandom_range(0, 20) | ($urandom() & 32'hFFFF_0000);
				1: value = (wide ? 32'h8000_0000 : 32'h0000_8000)
					+ $urandom_range(0, 4) - 32'd2 + ($urandom() & 32'hFFFF_0000);
				2: begin
					pow = 32'd1;
					repeat ($urandom_range(0, 9)) pow = pow * 32'd10;
					value = pow + $urandom_range(0, 2) - 32'd1;
				end
				3: value = 32'd1 << $urandom_range(0, 31);
				4: value = -$urandom_range(1, 20);
				default: value = $urandom();
			endcase
			add_number(kind, wide, value);
		end

		// hold reset, then release at a clock edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count < total_numbers) @(posedge clk);
		while (expected_glyphs.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Timeout guard
	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
